[rtl/npcs_pkg.sv]
// Shared types, constants and widths for the nearest palette color search block.
package npcs_pkg;

    // Palette size default
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Field widths
    localparam int COLOR_W  = 8;
    localparam int BRIGHT_W = 12;
    localparam int ENTRY_W  = 3 * COLOR_W + BRIGHT_W;
    localparam int SUM_W    = 18;
    localparam int RAD_W    = 26;
    localparam int ROOT_W   = 13;
    localparam int REM_W    = 15;
    localparam int STEP_W   = 4;
    localparam int COL_W    = 33;
    localparam int DIST_W   = 42;

    // Root iterations, two radicand bits each
    localparam logic [STEP_W-1:0] ROOT_LAST_STEP = STEP_W'(ROOT_W - 1);

    // Fixed-point constants (Q0.16)
    localparam logic [15:0] BRIGHT_SCALE = 16'd37837;
    localparam logic [15:0] BRIGHT_ROUND = 16'd32768;
    localparam logic [15:0] W_RED        = 16'd19661;
    localparam logic [15:0] W_GREEN      = 16'd38666;
    localparam logic [15:0] W_BLUE       = 16'd7209;
    localparam logic [15:0] W_BRIGHT     = 16'd45875;

    // Request commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Query operands held for the scan
    typedef struct packed {
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [BRIGHT_W-1:0] bright;
    } t_query;

    // Status from the brightness unit
    typedef struct packed {
        logic                done;
        logic [BRIGHT_W-1:0] bright;
    } t_bright_status;

    // Brightness unit sequencer
    typedef enum logic [1:0] {
        BR_IDLE,
        BR_ROOT,
        BR_SCALE
    } t_bright_state;

    // Top-level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BRIGHT,
        ST_SCAN,
        ST_OUT
    } t_state;

endpackage

[rtl/npcs_bright.sv]
// Brightness unit: squares sum, bit-serial integer square root, Q0.16 scale.
module npcs_bright (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_red,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_green,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_blue,
    output npcs_pkg::t_bright_status      o_status
);
    import npcs_pkg::*;

    t_bright_state r_state, n_state;

    logic [RAD_W-1:0]    r_x;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [STEP_W-1:0]   r_step;
    logic                r_done;
    logic [BRIGHT_W-1:0] r_bright;

    logic [15:0]         sq_r, sq_g, sq_b;
    logic [SUM_W-1:0]    sum_sq;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                fits;
    logic [29:0]         scaled;

    // Sum of squares of the request color
    assign sq_r   = i_red * i_red;
    assign sq_g   = i_green * i_green;
    assign sq_b   = i_blue * i_blue;
    assign sum_sq = SUM_W'(sq_r) + SUM_W'(sq_g) + SUM_W'(sq_b);

    // One restoring root step: bring in two radicand bits, try root*4+1
    assign rem_sh = {r_rem, r_x[RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    // Scale root by 1/sqrt(3) with rounding
    assign scaled = 30'(r_root) * 30'(BRIGHT_SCALE) + 30'(BRIGHT_ROUND);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == BR_SCALE);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BR_IDLE: begin
                if (i_start) begin
                    n_state = BR_ROOT;
                end
            end
            BR_ROOT: begin
                if (r_step == ROOT_LAST_STEP) begin
                    n_state = BR_SCALE;
                end
            end
            BR_SCALE: begin
                n_state = BR_IDLE;
            end
            default: begin
                n_state = BR_IDLE;
            end
        endcase
    end

    // Root datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BR_IDLE: begin
                r_x    <= {sum_sq, 8'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            BR_ROOT: begin
                r_x    <= {r_x[RAD_W-3:0], 2'b00};
                r_step <= r_step + STEP_W'(1);
                if (fits) begin
                    r_rem  <= REM_W'(rem_sh - trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(rem_sh);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            BR_SCALE: begin
                r_bright <= scaled[16 +: BRIGHT_W];
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

    assign o_status.done   = r_done;
    assign o_status.bright = r_bright;

endmodule

[rtl/npcs_pal_mem.sv]
// Palette memory: one write port, one registered read port.
module npcs_pal_mem #(
    parameter int DEPTH  = npcs_pkg::PALETTE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [npcs_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [npcs_pkg::ENTRY_W-1:0] o_rdata
);
    import npcs_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/npcs_dist.sv]
// Weighted distance pipeline: one palette entry per cycle, five stages.
module npcs_dist #(
    parameter int IDX_W = $clog2(npcs_pkg::PALETTE_ENTRIES_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic [npcs_pkg::ENTRY_W-1:0] i_entry,
    input  npcs_pkg::t_query             i_query,
    output logic                         o_valid,
    output logic [IDX_W-1:0]             o_idx,
    output logic [npcs_pkg::DIST_W-1:0]  o_dist
);
    import npcs_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0]  r_vld;
    logic [IDX_W-1:0]   r_idx [STAGES];

    logic [COLOR_W-1:0]  e_red, e_green, e_blue;
    logic [BRIGHT_W-1:0] e_bright;

    logic [COLOR_W-1:0]  r_dr, r_dg, r_db;
    logic [BRIGHT_W-1:0] r_dv;
    logic [15:0]         r_sr, r_sg, r_sb;
    logic [23:0]         r_sv;
    logic [31:0]         r_wr, r_wg, r_wb;
    logic [39:0]         r_wv;
    logic [COL_W-1:0]    r_col;
    logic [39:0]         r_bt;
    logic [DIST_W-1:0]   r_dist;

    // Unpack entry
    assign e_red    = i_entry[ENTRY_W-1 -: COLOR_W];
    assign e_green  = i_entry[ENTRY_W-COLOR_W-1 -: COLOR_W];
    assign e_blue   = i_entry[BRIGHT_W +: COLOR_W];
    assign e_bright = i_entry[BRIGHT_W-1:0];

    // Advance valid tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // Advance index tags
    always_ff @(posedge i_clk) begin
        r_idx[0] <= i_idx;
        for (int i = 1; i < STAGES; i++) begin
            r_idx[i] <= r_idx[i-1];
        end
    end

    // Stage 1: absolute differences
    always_ff @(posedge i_clk) begin
        r_dr <= (e_red > i_query.red)     ? e_red - i_query.red     : i_query.red - e_red;
        r_dg <= (e_green > i_query.green) ? e_green - i_query.green : i_query.green - e_green;
        r_db <= (e_blue > i_query.blue)   ? e_blue - i_query.blue   : i_query.blue - e_blue;
        r_dv <= (e_bright > i_query.bright) ? e_bright - i_query.bright
                                            : i_query.bright - e_bright;
    end

    // Stage 2: squares
    always_ff @(posedge i_clk) begin
        r_sr <= r_dr * r_dr;
        r_sg <= r_dg * r_dg;
        r_sb <= r_db * r_db;
        r_sv <= r_dv * r_dv;
    end

    // Stage 3: weights
    always_ff @(posedge i_clk) begin
        r_wr <= r_sr * W_RED;
        r_wg <= r_sg * W_GREEN;
        r_wb <= r_sb * W_BLUE;
        r_wv <= r_sv * W_BRIGHT;
    end

    // Stage 4: color sum, hold brightness term
    always_ff @(posedge i_clk) begin
        r_col <= COL_W'(r_wr) + COL_W'(r_wg) + COL_W'(r_wb);
        r_bt  <= r_wv;
    end

    // Stage 5: full-width distance
    always_ff @(posedge i_clk) begin
        r_dist <= DIST_W'({r_col, 8'd0}) + DIST_W'(r_bt);
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_idx   = r_idx[STAGES-1];
    assign o_dist  = r_dist;

endmodule

[rtl/nearest_palette_color_search.sv]
// Top level: palette load and nearest-color query sequencer.
//
//  channel  signals                                          direction
//  -------  -----------------------------------------------  ---------
//  request  i_valid, o_stall, i_command, i_entry_index,      in
//           i_red, i_green, i_blue
//  result   o_valid, i_stall, o_best_index                   out
//
// A load runs 13 square-root steps in the brightness unit, then scaling and
// the palette write. A query makes the same brightness pass, then one palette
// read per cycle through the read register and the five-stage distance
// pipeline, a final compare and the result load; the result shows in the
// same cycle that the next request can enter.
// Reset clears the sequencers and valid flags only; the palette holds nothing until loaded.
// A result waiting under i_stall does not block the next request; only a
// finished query waits for the result register to free up.
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic [7:0]                   i_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0] i_red,
    input  logic [npcs_pkg::COLOR_W-1:0] i_green,
    input  logic [npcs_pkg::COLOR_W-1:0] i_blue,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_best_index
);
    import npcs_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

    t_state r_state, n_state;

    logic                latch_in, mem_we, scan_start, out_load;
    logic                r_cmd;
    logic [7:0]          r_idx;
    t_query              r_query;
    t_bright_status      bright_st;

    logic [AW+7:0]       idx_ext;
    logic                in_range;
    logic [ENTRY_W-1:0]  wdata;

    logic                r_issue;
    logic [AW-1:0]       r_rd_addr;
    logic                r_rd_valid;
    logic [AW-1:0]       r_rd_idx;
    logic [ENTRY_W-1:0]  rdata;

    logic                dist_valid;
    logic [AW-1:0]       dist_idx;
    logic [DIST_W-1:0]   dist_val;
    logic [DIST_W-1:0]   r_best_dist;
    logic [AW-1:0]       r_best_idx;
    logic [AW+7:0]       best_ext;

    logic                r_out_valid;
    logic [7:0]          r_out_idx;

    // Load address and range check
    assign idx_ext  = {AW'(0), r_idx};
    assign in_range = (32'(r_idx) < PALETTE_ENTRIES);
    assign wdata    = {r_query.red, r_query.green, r_query.blue, bright_st.bright};

    // Brightness unit
    npcs_bright u_bright (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (latch_in),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .o_status (bright_st)
    );

    // Palette memory
    npcs_pal_mem #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (r_issue),
        .i_raddr (r_rd_addr),
        .o_rdata (rdata)
    );

    // Distance pipeline
    npcs_dist #(
        .IDX_W (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_entry (rdata),
        .i_query (r_query),
        .o_valid (dist_valid),
        .o_idx   (dist_idx),
        .o_dist  (dist_val)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state    = r_state;
        latch_in   = 1'b0;
        mem_we     = 1'b0;
        scan_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    latch_in = 1'b1;
                    n_state  = ST_BRIGHT;
                end
            end
            ST_BRIGHT: begin
                if (bright_st.done) begin
                    if (r_cmd == CMD_QUERY) begin
                        scan_start = 1'b1;
                        n_state    = ST_SCAN;
                    end else begin
                        mem_we  = in_range;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (dist_valid && (dist_idx == LAST)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    // Hold request fields; capture query brightness
    always_ff @(posedge i_clk) begin
        if (latch_in) begin
            r_cmd         <= i_command;
            r_idx         <= i_entry_index;
            r_query.red   <= i_red;
            r_query.green <= i_green;
            r_query.blue  <= i_blue;
        end
        if (scan_start) begin
            r_query.bright <= bright_st.bright;
        end
    end

    // Scan read issue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (scan_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_rd_addr == LAST)) begin
                r_issue <= 1'b0;
            end
            r_rd_valid <= r_issue;
        end
    end

    // Advance read address
    always_ff @(posedge i_clk) begin
        if (scan_start) begin
            r_rd_addr <= '0;
        end else if (r_issue) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        r_rd_idx <= r_rd_addr;
    end

    // Track best entry; entry 0 seeds, later ones must be strictly closer
    always_ff @(posedge i_clk) begin
        if (dist_valid && ((dist_idx == '0) || (dist_val < r_best_dist))) begin
            r_best_dist <= dist_val;
            r_best_idx  <= dist_idx;
        end
    end

    assign best_ext = {8'd0, r_best_idx};

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx <= best_ext[7:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_best_index = r_out_idx;

endmodule
